/* hw/rtl/ghte_pkg.sv */
// ---------------------------------------------------------------------------
// ghte_pkg
// Shared types and constants for the GPIO handshake transfer engine: item
// opcodes, register map, configuration and result bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package ghte_pkg;

  // Field widths fixed by the item and register formats
  localparam int DATA_W   = 16;
  localparam int BYTES_W  = 16;
  localparam int ADDR_W   = 5;
  localparam int REG_IDX_W = 3;
  localparam int APB_W    = 32;

  localparam logic [DATA_W-1:0] MASK16 = 16'hffff;
  localparam logic [DATA_W-1:0] MASK8  = 16'h00ff;

  // Item opcodes; the fourth code is ignored by the engine
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_READY = 2'd1,
    OP_INTR  = 2'd2
  } op_t;

  // Register indexes (byte address is index times four)
  localparam logic [REG_IDX_W-1:0] REG_WORD_MODE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_READ_DIRECTION = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_ENABLE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MATCH_PATTERN  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TRANSFER_BYTES = 3'd4;

  typedef struct packed {
    logic              word_mode;
    logic              read_direction;
    logic              pattern_enable;
    logic [DATA_W-1:0] match_pattern;
    logic [BYTES_W-1:0] transfer_bytes;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data_in;
    logic              periph_ready;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic               data_valid;
    logic               active;
    logic               done_res;
    logic               term_match;
    logic               term_count;
    logic               term_end;
    logic [BYTES_W-1:0] residual_bytes;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/ghte_cfg.sv */
// ---------------------------------------------------------------------------
// ghte_cfg
// APB register block: holds the transfer setup registers and serves reads.
// ---------------------------------------------------------------------------
`default_nettype none

module ghte_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ghte_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [ghte_pkg::APB_W-1:0]    pwdata,
  output logic      [ghte_pkg::APB_W-1:0]    prdata,
  output logic                               pready,
  output ghte_pkg::cfg_t                     cfg
);

  ghte_pkg::cfg_t cfg_r;
  logic [ghte_pkg::REG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign reg_idx = paddr[ghte_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Write the addressed register on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        ghte_pkg::REG_WORD_MODE:      cfg_r.word_mode      <= pwdata[0];
        ghte_pkg::REG_READ_DIRECTION: cfg_r.read_direction <= pwdata[0];
        ghte_pkg::REG_PATTERN_ENABLE: cfg_r.pattern_enable <= pwdata[0];
        ghte_pkg::REG_MATCH_PATTERN:
          cfg_r.match_pattern  <= pwdata[ghte_pkg::DATA_W-1:0];
        ghte_pkg::REG_TRANSFER_BYTES:
          cfg_r.transfer_bytes <= pwdata[ghte_pkg::BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    prdata = '0;
    case (reg_idx)
      ghte_pkg::REG_WORD_MODE:      prdata[0] = cfg_r.word_mode;
      ghte_pkg::REG_READ_DIRECTION: prdata[0] = cfg_r.read_direction;
      ghte_pkg::REG_PATTERN_ENABLE: prdata[0] = cfg_r.pattern_enable;
      ghte_pkg::REG_MATCH_PATTERN:
        prdata[ghte_pkg::DATA_W-1:0] = cfg_r.match_pattern;
      ghte_pkg::REG_TRANSFER_BYTES:
        prdata[ghte_pkg::BYTES_W-1:0] = cfg_r.transfer_bytes;
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/ghte_xfer.sv */
// ---------------------------------------------------------------------------
// ghte_xfer
// Transfer state and single-pass item logic: element counter, busy flag,
// pattern compare and residual calculation.
// ---------------------------------------------------------------------------
`default_nettype none

module ghte_xfer #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire ghte_pkg::item_t item,
  input  wire ghte_pkg::cfg_t  cfg,
  output ghte_pkg::res_t       res
);

  localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

  logic                         busy_r, busy_nxt;
  logic [COUNT_BITS-1:0]        rem_r, rem_nxt;
  logic [COUNT_BITS-1:0]        rem_dec;
  logic [31:0]                  rem_dec_w, rem_w;
  logic [ghte_pkg::BYTES_W-1:0] bytes_dec, bytes_cur;
  logic [ghte_pkg::DATA_W-1:0]  wmask, din_m, pat_m;
  logic [ghte_pkg::BYTES_W-1:0] n_elems;
  logic [31:0]                  n_sat;
  logic                         hit;

  // Element width, pattern and count preparation
  assign wmask     = cfg.word_mode ? ghte_pkg::MASK16 : ghte_pkg::MASK8;
  assign din_m     = item.data_in & wmask;
  assign pat_m     = cfg.match_pattern & wmask;
  assign hit       = cfg.read_direction & cfg.pattern_enable & (din_m == pat_m);
  assign n_elems   = cfg.word_mode ? {1'b0, cfg.transfer_bytes[ghte_pkg::BYTES_W-1:1]}
                                   : cfg.transfer_bytes;
  assign n_sat     = (32'(n_elems) > CNT_MAX) ? CNT_MAX : 32'(n_elems);

  // Elements left after this handshake, and both counts in bytes
  assign rem_dec   = (rem_r != '0) ? rem_r - COUNT_BITS'(1) : '0;
  assign rem_dec_w = 32'(rem_dec);
  assign rem_w     = 32'(rem_r);
  assign bytes_dec = cfg.word_mode ? {rem_dec_w[ghte_pkg::BYTES_W-2:0], 1'b0}
                                   : rem_dec_w[ghte_pkg::BYTES_W-1:0];
  assign bytes_cur = cfg.word_mode ? {rem_w[ghte_pkg::BYTES_W-2:0], 1'b0}
                                   : rem_w[ghte_pkg::BYTES_W-1:0];

  // Decide the result and next state for the item in the input register
  always_comb begin
    res      = '0;
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    case (item.op)
      ghte_pkg::OP_START: begin
        if (!busy_r) begin
          if (!item.periph_ready) begin
            res.done_res       = 1'b1;
            res.term_end       = 1'b1;
            res.residual_bytes = cfg.transfer_bytes;
          end else if (n_elems == '0) begin
            res.done_res   = 1'b1;
            res.term_count = 1'b1;
          end else begin
            rem_nxt  = n_sat[COUNT_BITS-1:0];
            busy_nxt = 1'b1;
          end
        end
      end
      ghte_pkg::OP_READY: begin
        if (busy_r) begin
          res.data_out   = din_m;
          res.data_valid = 1'b1;
          rem_nxt        = rem_dec;
          if (hit) begin
            res.done_res       = 1'b1;
            res.term_match     = 1'b1;
            res.residual_bytes = bytes_dec;
            res.term_count     = (bytes_dec == '0);
            busy_nxt           = 1'b0;
          end else if (rem_dec == '0) begin
            res.done_res   = 1'b1;
            res.term_count = 1'b1;
            busy_nxt       = 1'b0;
          end
        end
      end
      ghte_pkg::OP_INTR: begin
        if (busy_r) begin
          res.done_res       = 1'b1;
          res.term_end       = 1'b1;
          res.residual_bytes = bytes_cur;
          busy_nxt           = 1'b0;
        end
      end
      default: ;
    endcase
    // Drop the count once a transfer ends
    if (res.done_res) begin
      rem_nxt = '0;
    end
    res.active = busy_nxt;
  end

  // Advance the state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
    end else if (adv) begin
      busy_r <= busy_nxt;
      rem_r  <= rem_nxt;
    end
  end

  // A running transfer always has elements left; an idle one has none
  a_busy_has_elems: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r != '0))
    else $error("busy with zero elements left");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (rem_r == '0))
    else $error("element count left over while idle");

  // The last element handshake ends the transfer
  a_last_elem_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && busy_r && item.op == ghte_pkg::OP_READY && rem_r == COUNT_BITS'(1))
      |=> !busy_r)
    else $error("transfer still running after last element");

  // A finished transfer reports no activity, and data moves only on handshakes
  a_done_not_active: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.done_res) |-> (!res.active && !busy_nxt))
    else $error("done reported on an active transfer");

  a_data_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.data_valid) |-> (busy_r && item.op == ghte_pkg::OP_READY))
    else $error("data moved outside a running handshake");

endmodule

`default_nettype wire

/* hw/rtl/gpio_handshake_transfer_engine.sv */
// Flow: an accepted item enters the input register, then its result moves
// into the result register once that is empty or being taken. Throughput:
// one item per cycle unless the result side stalls; the counter update and
// pattern compare complete in the single stage between the two registers.
// Reset (rst_n low, synchronous): no transfer running, element count zero,
// all setup registers zero, both pipeline registers empty.
// ---------------------------------------------------------------------------
// gpio_handshake_transfer_engine
// Handshaked parallel transfer engine, interrupt mode: top level with the
// input register, the result register and the APB setup port.
// ---------------------------------------------------------------------------
`default_nettype none

module gpio_handshake_transfer_engine #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input item channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_op,
  input  wire logic [ghte_pkg::DATA_W-1:0]     in_data_in,
  input  wire logic                            in_periph_ready,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [ghte_pkg::DATA_W-1:0]     out_data_out,
  output logic                                 out_data_valid,
  output logic                                 out_active,
  output logic                                 out_done_res,
  output logic                                 out_term_match,
  output logic                                 out_term_count,
  output logic                                 out_term_end,
  output logic      [ghte_pkg::BYTES_W-1:0]    out_residual_bytes,
  // Setup port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ghte_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [ghte_pkg::APB_W-1:0]      pwdata,
  output logic      [ghte_pkg::APB_W-1:0]      prdata,
  output logic                                 pready
);

  ghte_pkg::cfg_t  cfg;
  ghte_pkg::item_t item_r, item_nxt;
  ghte_pkg::res_t  res, res_r;
  logic            item_vld_r, item_vld_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic            in_take, adv;

  ghte_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ghte_xfer #(
    .COUNT_BITS (COUNT_BITS)
  ) u_xfer (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Advance when the result register is empty or being taken
  assign adv      = item_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = item_vld_r & ~adv;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    item_nxt.op           = ghte_pkg::op_t'(in_op);
    item_nxt.data_in      = in_data_in;
    item_nxt.periph_ready = in_periph_ready;
    item_vld_nxt          = in_take | (item_vld_r & ~adv);
    out_vld_nxt           = adv | (out_vld_r & out_stall);
  end

  // Hold valid flags under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Capture payloads; these need no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_nxt;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_data_out       = res_r.data_out;
  assign out_data_valid     = res_r.data_valid;
  assign out_active         = res_r.active;
  assign out_done_res       = res_r.done_res;
  assign out_term_match     = res_r.term_match;
  assign out_term_count     = res_r.term_count;
  assign out_term_end       = res_r.term_end;
  assign out_residual_bytes = res_r.residual_bytes;

endmodule

`default_nettype wire

/* sim/ghte_transfer_checker.sv */
// ---------------------------------------------------------------------------
// ghte_transfer_checker
// Watches the item, result and APB ports of the transfer engine, keeps its
// own copy of the setup registers and transfer state, predicts the status
// of every accepted item and compares each returned result field by field.
// ---------------------------------------------------------------------------
module ghte_transfer_checker
  import ghte_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          in_op,
  input  logic [DATA_W-1:0]   in_data_in,
  input  logic                in_periph_ready,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [DATA_W-1:0]   out_data_out,
  input  logic                out_data_valid,
  input  logic                out_active,
  input  logic                out_done_res,
  input  logic                out_term_match,
  input  logic                out_term_count,
  input  logic                out_term_end,
  input  logic [BYTES_W-1:0]  out_residual_bytes,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [APB_W-1:0]    pwdata,
  input  logic                pready,
  output int                  pending,
  output int                  errors,
  output int                  results_seen,
  output int                  ends_match,
  output int                  ends_count,
  output int                  ends_end
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the setup registers and of the transfer state
  cfg_t                  shadow_cfg;
  logic [COUNT_BITS-1:0] elems_left;
  logic                  xfer_busy;

  // Status words predicted for accepted items, oldest first
  res_t awaited_status_q[$];

  int mismatch_cnt = 0;
  int result_cnt   = 0;
  int match_cnt    = 0;
  int count_cnt    = 0;
  int end_cnt      = 0;

  // Untransferred amount in bytes (elements doubled in word mode)
  function automatic logic [BYTES_W-1:0] bytes_left();
    longint unsigned b;
    b = elems_left;
    if (shadow_cfg.word_mode) b = b << 1;
    return b[BYTES_W-1:0];
  endfunction

  // Advance the transfer state by one item and return its status word
  function automatic res_t step_transfer(input logic [1:0] op,
                                         input logic [DATA_W-1:0] din,
                                         input logic ready);
    res_t              r;
    logic [DATA_W-1:0] wmask;
    logic [DATA_W-1:0] d;
    longint unsigned   n;
    longint unsigned   cmax;
    r     = '0;
    wmask = shadow_cfg.word_mode ? MASK16 : MASK8;
    cmax  = (64'd1 << COUNT_BITS) - 64'd1;
    if (op == OP_START && !xfer_busy) begin
      if (!ready) begin
        // peripheral not ready: end at once with every byte left
        r.done_res       = 1'b1;
        r.term_end       = 1'b1;
        r.residual_bytes = shadow_cfg.transfer_bytes;
      end else begin
        n = shadow_cfg.transfer_bytes;
        if (shadow_cfg.word_mode) n = n >> 1;
        if (n > cmax) n = cmax;
        if (n == 0) begin
          r.done_res   = 1'b1;
          r.term_count = 1'b1;
        end else begin
          elems_left = COUNT_BITS'(n);
          xfer_busy  = 1'b1;
        end
      end
    end else if (op == OP_READY && xfer_busy) begin
      d                = din & wmask;
      r.data_out       = d;
      r.data_valid     = 1'b1;
      if (elems_left != 0) elems_left = elems_left - 1'b1;
      if (shadow_cfg.read_direction && shadow_cfg.pattern_enable &&
          d == (shadow_cfg.match_pattern & wmask)) begin
        r.done_res       = 1'b1;
        r.term_match     = 1'b1;
        r.residual_bytes = bytes_left();
        r.term_count     = (r.residual_bytes == 0);
        xfer_busy        = 1'b0;
      end else if (elems_left == 0) begin
        r.done_res   = 1'b1;
        r.term_count = 1'b1;
        xfer_busy    = 1'b0;
      end
    end else if (op == OP_INTR && xfer_busy) begin
      r.done_res       = 1'b1;
      r.term_end       = 1'b1;
      r.residual_bytes = bytes_left();
      xfer_busy        = 1'b0;
    end
    if (!xfer_busy && r.done_res) elems_left = '0;
    r.active = xfer_busy;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
               $time, result_cnt, what, want, got);
  endtask

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) report_mismatch(what, want, got);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      shadow_cfg = '0;
      elems_left = '0;
      xfer_busy  = 1'b0;
      awaited_status_q.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_WORD_MODE:      shadow_cfg.word_mode      = pwdata[0];
          REG_READ_DIRECTION: shadow_cfg.read_direction = pwdata[0];
          REG_PATTERN_ENABLE: shadow_cfg.pattern_enable = pwdata[0];
          REG_MATCH_PATTERN:  shadow_cfg.match_pattern  = pwdata[DATA_W-1:0];
          REG_TRANSFER_BYTES: shadow_cfg.transfer_bytes = pwdata[BYTES_W-1:0];
          default: ;
        endcase
      end

      // Predict the status of each accepted item
      if (in_valid && !in_stall)
        awaited_status_q.push_back(step_transfer(in_op, in_data_in, in_periph_ready));

      // Compare each accepted result against the oldest prediction
      if (out_valid && !out_stall) begin
        got.data_out       = out_data_out;
        got.data_valid     = out_data_valid;
        got.active         = out_active;
        got.done_res       = out_done_res;
        got.term_match     = out_term_match;
        got.term_count     = out_term_count;
        got.term_end       = out_term_end;
        got.residual_bytes = out_residual_bytes;
        if (awaited_status_q.size() == 0) begin
          report_mismatch("result with no item pending", 0, got);
        end else begin
          want = awaited_status_q.pop_front();
          check_field("data_out", want.data_out, got.data_out);
          check_field("data_valid", want.data_valid, got.data_valid);
          check_field("active", want.active, got.active);
          check_field("done_res", want.done_res, got.done_res);
          check_field("term_match", want.term_match, got.term_match);
          check_field("term_count", want.term_count, got.term_count);
          check_field("term_end", want.term_end, got.term_end);
          check_field("residual_bytes", want.residual_bytes, got.residual_bytes);
          if (want.done_res) begin
            if (want.term_match) match_cnt++;
            else if (want.term_count) count_cnt++;
            else end_cnt++;
          end
        end
        result_cnt++;
      end
    end
    pending      <= awaited_status_q.size();
    errors       <= mismatch_cnt;
    results_seen <= result_cnt;
    ends_match   <= match_cnt;
    ends_count   <= count_cnt;
    ends_end     <= end_cnt;
  end

endmodule

/* sim/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Drives the transfer engine with directed and random start, handshake and
// interrupt items under random register settings, with random gaps on the
// item side and random stalls on the result side; the checker beside the
// engine predicts and compares, and this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_top;
  import ghte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CNT_BITS    = 16;
  localparam int         ITEM_TARGET = 1200;
  localparam int         QUIET_FROM  = 1050;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [1:0]          in_op           = OP_START;
  logic [DATA_W-1:0]   in_data_in      = '0;
  logic                in_periph_ready = 1'b0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [DATA_W-1:0]   out_data_out;
  logic                out_data_valid;
  logic                out_active;
  logic                out_done_res;
  logic                out_term_match;
  logic                out_term_count;
  logic                out_term_end;
  logic [BYTES_W-1:0]  out_residual_bytes;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [ADDR_W-1:0]   paddr           = '0;
  logic [APB_W-1:0]    pwdata          = '0;
  logic [APB_W-1:0]    prdata;
  logic                pready;

  int pending;
  int errors;
  int results_seen;
  int ends_match;
  int ends_count;
  int ends_end;

  int                items_sent     = 0;
  int                settings_used  = 0;
  int                gap_pct        = 0;
  int                stall_pct      = 0;
  int                stall_left     = 0;
  logic [DATA_W-1:0] cur_pattern    = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  gpio_handshake_transfer_engine #(
    .COUNT_BITS (CNT_BITS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_data_in         (in_data_in),
    .in_periph_ready    (in_periph_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_out       (out_data_out),
    .out_data_valid     (out_data_valid),
    .out_active         (out_active),
    .out_done_res       (out_done_res),
    .out_term_match     (out_term_match),
    .out_term_count     (out_term_count),
    .out_term_end       (out_term_end),
    .out_residual_bytes (out_residual_bytes),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  ghte_transfer_checker #(
    .COUNT_BITS (CNT_BITS)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_data_in         (in_data_in),
    .in_periph_ready    (in_periph_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_out       (out_data_out),
    .out_data_valid     (out_data_valid),
    .out_active         (out_active),
    .out_done_res       (out_done_res),
    .out_term_match     (out_term_match),
    .out_term_count     (out_term_count),
    .out_term_end       (out_term_end),
    .out_residual_bytes (out_residual_bytes),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .pending            (pending),
    .errors             (errors),
    .results_seen       (results_seen),
    .ends_match         (ends_match),
    .ends_count         (ends_count),
    .ends_end           (ends_end)
  );

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (!rst_n || stall_pct == 0) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one item, after an optional gap, and hold it until accepted
  task automatic send_item(input logic [1:0] op, input logic [DATA_W-1:0] data,
                           input logic ready);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_data_in      <= data;
    in_periph_ready <= ready;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_engine();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_engine(input logic wm, input logic rd, input logic pe,
                                input logic [DATA_W-1:0] pat,
                                input logic [BYTES_W-1:0] nbytes);
    write_reg(REG_WORD_MODE, APB_W'(wm));
    write_reg(REG_READ_DIRECTION, APB_W'(rd));
    write_reg(REG_PATTERN_ENABLE, APB_W'(pe));
    write_reg(REG_MATCH_PATTERN, APB_W'(pat));
    write_reg(REG_TRANSFER_BYTES, APB_W'(nbytes));
    cur_pattern = pat;
    settings_used++;
  endtask

  // Bias handshake data toward the pattern so early stops happen often
  function automatic logic [DATA_W-1:0] handshake_data();
    case ($urandom_range(0, 7))
      0:       return cur_pattern;
      1:       return {8'($urandom_range(0, 255)), cur_pattern[7:0]};
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed transfers with random content, some loose noise
  task automatic run_transfers(input int quota);
    int stop_at;
    int len;
    int pick;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 4) != 0) begin
        send_item(OP_START, 16'($urandom), $urandom_range(0, 7) != 0);
        len = $urandom_range(0, 16);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) send_item(OP_INTR, 16'($urandom), 1'($urandom));
          else if (pick == 1) send_item(OP_START, 16'($urandom), 1'($urandom));
          else if (pick == 2) send_item(OP_UNUSED, 16'($urandom), 1'($urandom));
          else send_item(OP_READY, handshake_data(), 1'($urandom));
        end
      end else begin
        send_item(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
      end
    end
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 8;
      default: return 30;
    endcase
  endfunction

  function automatic logic [BYTES_W-1:0] pick_byte_count();
    case ($urandom_range(0, 9))
      0:       return 16'hffff;
      1:       return 16'h0000;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  initial begin
    logic [DATA_W-1:0] pat;
    repeat (2) @(posedge clk);
    rst_n     <= 1'b1;
    gap_pct   = pick_idle_pct();
    stall_pct <= pick_idle_pct();
    @(posedge clk);

    // Idle engine: everything but a start is dropped; zero count at reset
    send_item(OP_READY, 16'hffff, 1'b1);
    send_item(OP_INTR, 16'h0000, 1'b0);
    send_item(OP_UNUSED, 16'h5555, 1'b1);
    send_item(OP_START, 16'h0000, 1'b1);
    send_item(OP_START, 16'h0000, 1'b0);
    drain_engine();

    // Byte-mode write of three bytes, with a start ignored mid-transfer
    program_engine(1'b0, 1'b0, 1'b0, 16'h0000, 16'd3);
    send_item(OP_START, 16'h0000, 1'b1);
    send_item(OP_READY, 16'hffff, 1'b0);
    send_item(OP_START, 16'h1234, 1'b1);
    send_item(OP_READY, 16'h0000, 1'b1);
    send_item(OP_READY, 16'ha5a5, 1'b1);
    drain_engine();

    // Word-mode read at full count: pattern stop, interrupt, not ready
    program_engine(1'b1, 1'b1, 1'b1, 16'hffff, 16'hffff);
    send_item(OP_START, 16'h0000, 1'b1);
    send_item(OP_READY, 16'h1234, 1'b1);
    send_item(OP_READY, 16'hffff, 1'b1);
    send_item(OP_START, 16'h0000, 1'b1);
    send_item(OP_READY, 16'h00ff, 1'b1);
    send_item(OP_INTR, 16'hffff, 1'b1);
    send_item(OP_START, 16'hffff, 1'b0);
    drain_engine();

    // Word mode with one byte: the odd byte is dropped, nothing to move
    program_engine(1'b1, 1'b0, 1'b1, 16'hffff, 16'd1);
    send_item(OP_START, 16'h0000, 1'b1);
    drain_engine();

    // Pattern hit on the last byte sets both match and count
    program_engine(1'b0, 1'b1, 1'b1, 16'h005a, 16'd2);
    send_item(OP_START, 16'h0000, 1'b1);
    send_item(OP_READY, 16'h0000, 1'b1);
    send_item(OP_READY, 16'h125a, 1'b1);
    drain_engine();

    // Random phases, each under fresh register settings
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0:       pat = 16'h0000;
        1:       pat = 16'hffff;
        default: pat = 16'($urandom);
      endcase
      program_engine(1'($urandom), 1'($urandom), 1'($urandom), pat, pick_byte_count());
      if (items_sent >= QUIET_FROM) begin
        gap_pct   = 0;
        stall_pct <= 0;
      end else begin
        gap_pct   = pick_idle_pct();
        stall_pct <= pick_idle_pct();
      end
      run_transfers($urandom_range(40, 80));
      drain_engine();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d items over %0d register settings; %0d results compared",
             items_sent, settings_used, results_seen);
    $display("Transfers closed by pattern %0d, by count %0d, by interrupt or not ready %0d",
             ends_match, ends_count, ends_end);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ghte_pkg.sv
hw/rtl/ghte_cfg.sv
hw/rtl/ghte_xfer.sv
hw/rtl/gpio_handshake_transfer_engine.sv
sim/ghte_transfer_checker.sv
sim/tb_top.sv
